@@ rtl/pcc_pkg.sv @@
// pcc_pkg: shared types, register indexes and saturation helpers for the
// PID controller block. No dependencies; imported by every RTL module.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INT_LIMIT = 3'd5;

  localparam logic        FUNC_STEP  = 1'b0;
  localparam logic        FUNC_CLEAR = 1'b1;

  // Divider: 32-bit magnitude scaled by 2^16 gives a 48-bit dividend
  localparam int unsigned DivSteps = 48;
  localparam int unsigned DivCntW  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ERR,
    ST_MUL_EI,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_WAIT_D,
    ST_MUL_D,
    ST_ACC_D,
    ST_CLAMP
  } pcc_state_e;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] mag;
    logic [23:0] divisor;
  } pcc_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } pcc_div_rsp_t;

  // Saturate a 50-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_0000_7FFF_FFFF;
    lo = -50'sh0_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/pcc_div.sv @@
// pcc_div: restoring serial divider for the derivative term, one quotient
// bit per cycle, with signed saturation of the result. Uses pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_div import pcc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pcc_div_req_t req_i,
  output pcc_div_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [47:0]        num_q, num_d;
  logic [23:0]        rem_q, rem_d;
  logic [23:0]        dvs_q, dvs_d;
  logic               neg_q, neg_d;

  logic [24:0] trial;
  logic [24:0] trial_sub;
  logic        ge;
  logic [31:0] quot;

  assign trial     = {rem_q, num_q[47]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      num_d  = {req_i.mag, 16'h0000};
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? trial_sub[23:0] : trial[23:0];
      num_d = {num_q[46:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // apply sign and saturate to 32 bits
  always_comb begin
    if (neg_q) begin
      if (num_q > 48'h0000_8000_0000) begin
        quot = 32'h8000_0000;
      end else begin
        quot = ~num_q[31:0] + 32'd1;
      end
    end else begin
      if (num_q > 48'h0000_7FFF_FFFF) begin
        quot = 32'h7FFF_FFFF;
      end else begin
        quot = num_q[31:0];
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot;

endmodule

`default_nettype wire

@@ rtl/pid_controller_clamped.sv @@
// PID controller step in signed Q16.16 with anti-windup and output clamp.
// A control step waits on the serial divider for the derivative (the
// shared 33x33 multiplier runs alongside it); a clear, or a step with a
// zero time_step, does not use the divider. The block takes one word at
// a time; a finished word waits in the output register while the next
// word is accepted.
// Depends on pcc_pkg and pcc_div.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped import pcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               func_i,
  input  wire logic signed [31:0] target_i,
  input  wire logic signed [31:0] measured_i,
  input  wire logic [23:0]        time_step_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] drive_o
);

  pcc_state_e state_q, state_d;

  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [31:0] out_min_q, out_max_q;
  logic [30:0]        int_limit_q;

  logic signed [31:0] target_q, measured_q;
  logic [23:0]        dt_q;

  logic signed [31:0] err_q, last_err_q, integ_q, deriv_q;
  logic signed [65:0] prod_q;
  logic signed [33:0] acc_q;
  logic               out_valid_q;
  logic signed [31:0] drive_q;

  logic               out_free;
  logic               in_acc;
  logic               div_ok;

  // sequencer controls
  logic mul_en, err_en, integ_en, acc_ld, acc_add, deriv_ld, div_start, fin_clear, fin_step;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] prod_sat;
  logic signed [32:0] diff;
  logic signed [32:0] diff_abs;
  logic signed [32:0] sub33;
  logic signed [32:0] integ_sum;
  logic signed [32:0] lim33;
  logic signed [31:0] integ_new;
  logic signed [31:0] clamped;

  pcc_div_req_t div_req;
  pcc_div_rsp_t div_rsp;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign div_ok      = (dt_q == 24'd0) || div_rsp.done;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = (func_i == FUNC_CLEAR) ? ST_CLEAR : ST_ERR;
      ST_CLEAR:  if (out_free) state_d = ST_IDLE;
      ST_ERR:    state_d = ST_MUL_EI;
      ST_MUL_EI: state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_ACC_I;
      ST_ACC_I:  state_d = ST_WAIT_D;
      ST_WAIT_D: if (div_ok) state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_ACC_D;
      ST_ACC_D:  state_d = ST_CLAMP;
      ST_CLAMP:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_en    = 1'b0;
    err_en    = 1'b0;
    integ_en  = 1'b0;
    acc_ld    = 1'b0;
    acc_add   = 1'b0;
    deriv_ld  = 1'b0;
    div_start = 1'b0;
    fin_clear = 1'b0;
    fin_step  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_CLEAR:  fin_clear = out_free;
      ST_ERR:    err_en = 1'b1;
      ST_MUL_EI: begin
        mul_en    = 1'b1;
        mul_a     = {err_q[31], err_q};
        mul_b     = {9'd0, dt_q};
        div_start = (dt_q != 24'd0);
      end
      ST_INTEG:  integ_en = 1'b1;
      ST_MUL_P:  begin
        mul_en = 1'b1;
        mul_a  = {gain_p_q[31], gain_p_q};
        mul_b  = {err_q[31], err_q};
      end
      ST_MUL_I:  begin
        mul_en = 1'b1;
        acc_ld = 1'b1;
        mul_a  = {gain_i_q[31], gain_i_q};
        mul_b  = {integ_q[31], integ_q};
      end
      ST_ACC_I:  acc_add = 1'b1;
      ST_WAIT_D: deriv_ld = div_ok;
      ST_MUL_D:  begin
        mul_en = 1'b1;
        mul_a  = {gain_d_q[31], gain_d_q};
        mul_b  = {deriv_q[31], deriv_q};
      end
      ST_ACC_D:  acc_add = 1'b1;
      ST_CLAMP:  fin_step = out_free;
      default:   ;
    endcase
  end

  // datapath
  assign prod_sat = sat32(prod_q[65:16]);
  assign sub33    = {target_q[31], target_q} - {measured_q[31], measured_q};

  assign diff     = {err_q[31], err_q} - {last_err_q[31], last_err_q};
  assign diff_abs = diff[32] ? -diff : diff;

  assign div_req.start   = div_start;
  assign div_req.neg     = diff[32];
  assign div_req.mag     = diff_abs[31:0];
  assign div_req.divisor = dt_q;

  assign integ_sum = {integ_q[31], integ_q} + {prod_sat[31], prod_sat};
  assign lim33     = {2'b00, int_limit_q};

  always_comb begin
    if (integ_sum > lim33) begin
      integ_new = lim33[31:0];
    end else if (integ_sum < -lim33) begin
      integ_new = 32'(-lim33);
    end else begin
      integ_new = integ_sum[31:0];
    end
  end

  // low clamp wins when the limits are inverted
  always_comb begin
    if (acc_q < $signed({{2{out_min_q[31]}}, out_min_q})) begin
      clamped = out_min_q;
    end else if (acc_q > $signed({{2{out_max_q[31]}}, out_max_q})) begin
      clamped = out_max_q;
    end else begin
      clamped = acc_q[31:0];
    end
  end

  pcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control state, configuration and stored controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_min_q   <= 32'sh8000_0000;
      out_max_q   <= 32'sh7FFF_FFFF;
      int_limit_q <= 31'h7FFF_FFFF;
      last_err_q  <= '0;
      integ_q     <= '0;
    end else begin
      state_q <= state_d;
      if (fin_clear || fin_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GAIN_P:    gain_p_q    <= cfg_data_i;
          REG_GAIN_I:    gain_i_q    <= cfg_data_i;
          REG_GAIN_D:    gain_d_q    <= cfg_data_i;
          REG_OUT_MIN:   out_min_q   <= cfg_data_i;
          REG_OUT_MAX:   out_max_q   <= cfg_data_i;
          REG_INT_LIMIT: int_limit_q <= cfg_data_i[30:0];
          default:       ;
        endcase
      end
      if (fin_clear) begin
        last_err_q <= '0;
        integ_q    <= '0;
      end else begin
        if (fin_step) last_err_q <= err_q;
        if (integ_en) integ_q <= integ_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q   <= target_i;
      measured_q <= measured_i;
      dt_q       <= time_step_i;
    end
    if (err_en) err_q <= sat32({{17{sub33[32]}}, sub33});
    if (mul_en) prod_q <= mul_a * mul_b;
    if (acc_ld) begin
      acc_q <= {{2{prod_sat[31]}}, prod_sat};
    end else if (acc_add) begin
      acc_q <= acc_q + {{2{prod_sat[31]}}, prod_sat};
    end
    if (deriv_ld) deriv_q <= (dt_q == 24'd0) ? 32'sd0 : div_rsp.quot;
    if (fin_clear) begin
      drive_q <= '0;
    end else if (fin_step) begin
      drive_q <= clamped;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pcc_checker.sv @@
// pcc_checker: port-level assertions for pid_controller_clamped, with the
// bind that attaches them. Uses pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_checker import pcc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               func_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] drive_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("result word changed while stalled");

  // busy after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a word");

  // a clear accepted while no result waits gives a valid zero drive after the clear state
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_CLEAR) && !out_valid_o
      |-> ##2 (out_valid_o && drive_o == 32'sd0))
    else $error("clear did not return zero");

  // a new result coincides with the return to idle
  a_rise_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while still busy");

endmodule

bind pid_controller_clamped pcc_checker u_pcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_o     (drive_o)
);

`default_nettype wire

@@ test/pid_drive_checker.sv @@
// pid_drive_checker: watches the register, input and result channels of the
// PID controller, predicts each drive word and compares it in order.
// Depends on pcc_pkg for the register index codes and the func codes.
`timescale 1ns / 1ps

module pid_drive_checker import pcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               func_i,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] measured_i,
  input  logic [23:0]        time_step_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] drive_i,
  output int                 faults_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam longint signed WordMax   = 64'sd2147483647;
  localparam longint signed WordMin   = -64'sd2147483648;
  localparam int            ReportCap = 10;

  // Register copies and controller state, all held at full width
  longint signed kp, ki, kd, drive_lo, drive_hi, integ_bound;
  longint signed prev_err, integ_acc;

  logic signed [31:0] expected_drive_q[$];
  logic signed [31:0] want;

  function automatic longint signed clip_word(input longint signed v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  // Q16.16 product: floor the 16 dropped bits, then saturate
  function automatic longint signed qscale(input longint signed a, input longint signed b);
    return clip_word((a * b) >>> 16);
  endfunction

  function automatic logic signed [31:0] next_drive(input logic op, input longint signed tgt,
                                                   input longint signed meas,
                                                   input longint signed dt);
    longint signed err, integ, deriv, total;
    if (op == FUNC_CLEAR) begin
      prev_err = 0;
      integ_acc = 0;
      return '0;
    end
    err = clip_word(tgt - meas);
    integ = integ_acc + clip_word((err * dt) >>> 16);
    if (integ > integ_bound) integ = integ_bound;
    if (integ < -integ_bound) integ = -integ_bound;
    integ_acc = integ;
    // Signed division truncates toward zero
    deriv = (dt > 0) ? clip_word(((err - prev_err) * 65536) / dt) : 0;
    total = qscale(kp, err) + qscale(ki, integ) + qscale(kd, deriv);
    // Lower bound wins when the clamp is inverted
    if (total < drive_lo) begin
      total = drive_lo;
    end else if (total > drive_hi) begin
      total = drive_hi;
    end
    prev_err = err;
    return total[31:0];
  endfunction

  task automatic flag_fault(input string what);
    faults_o++;
    if (faults_o <= ReportCap) $display("%s", what);
  endtask

  initial begin
    faults_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      kp = 0;
      ki = 0;
      kd = 0;
      drive_lo = WordMin;
      drive_hi = WordMax;
      integ_bound = WordMax;
      prev_err = 0;
      integ_acc = 0;
      expected_drive_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_GAIN_P:    kp = $signed(cfg_data_i);
          REG_GAIN_I:    ki = $signed(cfg_data_i);
          REG_GAIN_D:    kd = $signed(cfg_data_i);
          REG_OUT_MIN:   drive_lo = $signed(cfg_data_i);
          REG_OUT_MAX:   drive_hi = $signed(cfg_data_i);
          REG_INT_LIMIT: integ_bound = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_drive_q.push_back(next_drive(func_i, target_i, measured_i, time_step_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          flag_fault($sformatf("drive word %0d arrived with nothing expected", drive_i));
        end else begin
          want = expected_drive_q.pop_front();
          if (drive_i !== want) begin
            flag_fault($sformatf("drive mismatch at word %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                                 checked_o, want, want, drive_i, drive_i));
          end
          checked_o++;
        end
      end
    end
    pending_o = expected_drive_q.size();
  end

endmodule

@@ test/pid_controller_clamped_tb.sv @@
// pid_controller_clamped_tb: drives the PID controller through directed and
// random register settings and words; pid_drive_checker predicts the drive.
// Depends on pcc_pkg, pid_controller_clamped and pid_drive_checker.
`timescale 1ns / 1ps

module pid_controller_clamped_tb;
  import pcc_pkg::*;

  localparam logic [31:0]        QOne          = 32'h0001_0000;
  localparam logic [31:0]        WordMaxBits   = 32'h7FFF_FFFF;
  localparam logic [31:0]        WordMinBits   = 32'h8000_0000;
  localparam logic [23:0]        DtMax         = 24'hFF_FFFF;
  localparam logic [CfgIdxW-1:0] RegSpareLo    = REG_INT_LIMIT + CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSpareHi    = '1;
  localparam int                 RandomPhases  = 8;
  localparam int                 WordsPerPhase = 48;
  localparam int                 SettleCycles  = 64;
  localparam int                 WatchdogLimit = 4000;

  typedef enum int {RxSteady, RxCoin, RxSparse, RxBursty} rx_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_STEP;
  logic signed [31:0] target = '0;
  logic signed [31:0] measured = '0;
  logic [23:0]        time_step = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] drive;

  int faults, pending, checked;
  int words_sent = 0;
  int clears_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  rx_mode_e rx_mode = RxSteady;
  int rx_left = 0;

  pid_controller_clamped dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .target_i    (target),
    .measured_i  (measured),
    .time_step_i (time_step),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .drive_o     (drive)
  );

  pid_drive_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .target_i    (target),
    .measured_i  (measured),
    .time_step_i (time_step),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .drive_i     (drive),
    .faults_o    (faults),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: pick a new stall pattern at random whenever the current run ends
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxSteady: out_ready <= 1'b1;
      RxCoin:   out_ready <= $urandom_range(0, 1);
      RxSparse: out_ready <= ($urandom_range(0, 5) == 0);
      default:  out_ready <= ((rx_left % 32) < 4);
    endcase
  end

  // Watchdog: end the run if no word moves on any channel for too long
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no progress for %0d cycles, %0d results outstanding", WatchdogLimit, pending);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Leaves valid high after acceptance so the next word can follow at once
  task automatic send_word(input logic op, input logic [31:0] tgt, input logic [31:0] meas,
                           input logic [23:0] dt);
    @(negedge clk);
    func = op;
    target = tgt;
    measured = meas;
    time_step = dt;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (op == FUNC_CLEAR) clears_sent++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted drive word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [31:0] bound);
    drain_results();
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_INT_LIMIT, bound);
    if ($urandom_range(0, 1)) write_reg(RegSpareLo, $urandom());
    settings_used++;
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return WordMaxBits;
      1:       return WordMinBits;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? WordMaxBits : WordMinBits;
      2:       return $urandom();
      3:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DtMax;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 24'h02_0000);
    endcase
  endfunction

  task automatic load_random_settings();
    logic [31:0] lo, hi, bound, span;
    span = $urandom_range(0, 32'h0100_0000);
    case ($urandom_range(0, 3))
      0: begin
        lo = WordMinBits;
        hi = WordMaxBits;
      end
      1: begin
        lo = -span;
        hi = span;
      end
      2: begin
        // inverted clamp
        lo = span;
        hi = -span - 32'h0001_0000;
      end
      default: begin
        lo = $urandom();
        hi = $urandom();
      end
    endcase
    case ($urandom_range(0, 3))
      0:       bound = '0;
      1:       bound = 32'hFFFF_FFFF;
      2:       bound = $urandom_range(0, 32'h0010_0000);
      default: bound = $urandom();
    endcase
    load_settings(pick_gain(), pick_gain(), pick_gain(), lo, hi, bound);
  endtask

  initial begin
    int remaining, burst;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Unit proportional gain, small I and D gains, wide clamp, integral bound written with bit 31 set
    load_settings(QOne, 32'h0000_8000, 32'h0000_0100, WordMinBits, WordMaxBits,
                  32'hFFFF_FFFF);
    write_reg(RegSpareLo, 32'hDEAD_BEEF);
    write_reg(RegSpareHi, 32'h0000_0000);
    send_word(FUNC_STEP,  WordMaxBits, WordMinBits, DtMax);
    send_word(FUNC_STEP,  WordMinBits, WordMaxBits, '0);
    send_word(FUNC_STEP,  '0, '0, 24'h00_0001);
    send_word(FUNC_STEP,  QOne, '0, 24'h00_0001);
    send_word(FUNC_STEP,  WordMinBits, WordMaxBits, 24'h00_0001);
    send_word(FUNC_CLEAR, WordMaxBits, WordMinBits, DtMax);
    send_word(FUNC_STEP,  '0, QOne, '0);
    send_word(FUNC_STEP,  32'h0003_0000, QOne, 24'h01_0000);
    send_word(FUNC_STEP,  32'hFFFD_0000, 32'h0002_8000, 24'h00_4000);
    send_word(FUNC_CLEAR, '0, '0, '0);
    send_word(FUNC_STEP,  WordMaxBits, '0, DtMax);
    send_word(FUNC_STEP,  '0, '0, '0);

    // Extreme gains, inverted clamp, zero integral bound
    load_settings(WordMinBits, WordMaxBits, WordMinBits, QOne, 32'hFFFF_0000, '0);
    send_word(FUNC_STEP,  WordMaxBits, WordMinBits, DtMax);
    send_word(FUNC_STEP,  WordMinBits, WordMaxBits, 24'h00_0001);
    send_word(FUNC_STEP,  '0, '0, '0);
    send_word(FUNC_STEP,  32'h0000_8000, '0, 24'h00_0100);
    send_word(FUNC_CLEAR, WordMinBits, WordMaxBits, '0);
    send_word(FUNC_STEP,  32'hFFFF_8000, '0, 24'h00_0100);
    send_word(FUNC_STEP,  QOne, QOne, DtMax);

    // Opposite extremes, narrow clamp, small integral bound
    load_settings(WordMaxBits, WordMinBits, WordMaxBits, 32'hFFFB_0000, 32'h0005_0000,
                  32'h0002_0000);
    send_word(FUNC_STEP,  32'h0001_0000, '0, 24'h01_0000);
    send_word(FUNC_STEP,  32'h0004_0000, '0, 24'h01_0000);
    send_word(FUNC_STEP,  WordMinBits, '0, DtMax);
    send_word(FUNC_STEP,  '0, '0, 24'h00_0001);
    send_word(FUNC_STEP,  WordMaxBits, WordMaxBits, '0);
    send_word(FUNC_CLEAR, '0, '0, DtMax);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      load_random_settings();
      remaining = WordsPerPhase;
      while (remaining > 0) begin
        burst = $urandom_range(1, 12);
        while (burst > 0 && remaining > 0) begin
          send_word(($urandom_range(0, 11) == 0) ? FUNC_CLEAR : FUNC_STEP,
                    pick_q16(), pick_q16(), pick_dt());
          burst--;
          remaining--;
        end
        case ($urandom_range(0, 7))
          0:       hold_off($urandom_range(20, 80));
          1, 2, 3: hold_off(0);
          default: hold_off($urandom_range(1, 4));
        endcase
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);

    $display("Sent %0d words (%0d clears) under %0d register settings;", words_sent,
             clears_sent, settings_used);
    $display("checked %0d drive words, %0d mismatches", checked, faults);
    if (faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pcc_pkg.sv
rtl/pcc_div.sv
rtl/pid_controller_clamped.sv
rtl/pcc_checker.sv
test/pid_drive_checker.sv
test/pid_controller_clamped_tb.sv
